@@ src/ethp_pkg.sv @@
package ethp_pkg;

  localparam int ETH_HEADER_BYTES = 14;

  localparam logic [6:0] EthHdr7 = 7'(ETH_HEADER_BYTES);
  localparam logic [7:0] EthHdr8 = 8'(ETH_HEADER_BYTES);
  localparam logic [6:0] MaxPos = 7'd127;
  localparam logic [3:0] MinHdrWords = 4'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IP = 8'd0;

  localparam logic [2:0] ST_TCP_OK = 3'd0;
  localparam logic [2:0] ST_BAD_IP = 3'd1;
  localparam logic [2:0] ST_UDP = 3'd2;
  localparam logic [2:0] ST_ICMP = 3'd3;
  localparam logic [2:0] ST_IP = 3'd4;
  localparam logic [2:0] ST_OTHER = 3'd5;
  localparam logic [2:0] ST_BAD_TCP = 3'd6;
  localparam logic [2:0] ST_TRUNC = 3'd7;

  typedef struct packed {
    logic [7:0] frame_len;
    logic [3:0] ip_words;
    logic [3:0] tcp_words;
    logic [15:0] total_len;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [7:0] proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0] flags;
    logic [31:0] pkt_num;
  } frame_rec_t;

endpackage

@@ src/ethp_front.sv @@
module ethp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                q_full,
  output logic                push,
  output ethp_pkg::frame_rec_t rec
);

  logic [6:0] pos, pos_next;
  logic [3:0] ihl, ihl_next;
  logic [3:0] tcpw, tcpw_next;
  logic [15:0] total, total_next;
  logic [47:0] dmac, dmac_next;
  logic [47:0] smac, smac_next;
  logic [31:0] sip, sip_next;
  logic [31:0] dip, dip_next;
  logic [7:0] proto, proto_next;
  logic [15:0] sport, sport_next;
  logic [15:0] dport, dport_next;
  logic [7:0] flags, flags_next;
  logic [31:0] frame_cnt;

  logic accept;
  logic [6:0] ip_off;
  logic [6:0] ihl_bytes;
  logic [6:0] tcp_off;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && last_byte;

  assign ip_off = pos - ethp_pkg::EthHdr7;
  assign ihl_bytes = {1'b0, ihl, 2'b00};
  assign tcp_off = ip_off - ihl_bytes;

  always_comb begin
    ihl_next = ihl;
    tcpw_next = tcpw;
    total_next = total;
    dmac_next = dmac;
    smac_next = smac;
    sip_next = sip;
    dip_next = dip;
    proto_next = proto;
    sport_next = sport;
    dport_next = dport;
    flags_next = flags;

    if (pos < 7'd6) begin
      dmac_next[{3'(3'd5 - pos[2:0]), 3'b000} +: 8] = data_byte;
    end else if (pos < 7'd12) begin
      smac_next[{3'(7'd11 - pos), 3'b000} +: 8] = data_byte;
    end

    if (pos >= ethp_pkg::EthHdr7) begin
      if (ip_off == 7'd0) begin
        ihl_next = data_byte[3:0];
      end else if (ip_off == 7'd2) begin
        total_next[15:8] = data_byte;
      end else if (ip_off == 7'd3) begin
        total_next[7:0] = data_byte;
      end else if (ip_off == 7'd9) begin
        proto_next = data_byte;
      end else if (ip_off >= 7'd12 && ip_off <= 7'd15) begin
        sip_next[{2'(7'd15 - ip_off), 3'b000} +: 8] = data_byte;
      end else if (ip_off >= 7'd16 && ip_off <= 7'd19) begin
        dip_next[{2'(7'd19 - ip_off), 3'b000} +: 8] = data_byte;
      end

      if (ihl >= ethp_pkg::MinHdrWords && ip_off >= ihl_bytes) begin
        if (tcp_off <= 7'd1) begin
          sport_next[{~tcp_off[0], 3'b000} +: 8] = data_byte;
        end else if (tcp_off <= 7'd3) begin
          dport_next[{~tcp_off[0], 3'b000} +: 8] = data_byte;
        end else if (tcp_off == 7'd12) begin
          tcpw_next = data_byte[7:4];
        end else if (tcp_off == 7'd13) begin
          flags_next = data_byte;
        end
      end
    end

    pos_next = (pos < ethp_pkg::MaxPos) ? pos + 7'd1 : ethp_pkg::MaxPos;
  end

  always_comb begin
    rec.frame_len = {1'b0, pos} + 8'd1;
    rec.ip_words = ihl_next;
    rec.tcp_words = tcpw_next;
    rec.total_len = total_next;
    rec.dmac = dmac_next;
    rec.smac = smac_next;
    rec.sip = sip_next;
    rec.dip = dip_next;
    rec.proto = proto_next;
    rec.sport = sport_next;
    rec.dport = dport_next;
    rec.flags = flags_next;
    rec.pkt_num = frame_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos <= '0;
      ihl <= '0;
      tcpw <= '0;
      total <= '0;
      dmac <= '0;
      smac <= '0;
      sip <= '0;
      dip <= '0;
      proto <= '0;
      sport <= '0;
      dport <= '0;
      flags <= '0;
    end else if (accept) begin
      pos <= pos_next;
      ihl <= ihl_next;
      tcpw <= tcpw_next;
      total <= total_next;
      dmac <= dmac_next;
      smac <= smac_next;
      sip <= sip_next;
      dip <= dip_next;
      proto <= proto_next;
      sport <= sport_next;
      dport <= dport_next;
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= 32'd1;
    end else if (push) begin
      frame_cnt <= frame_cnt + 32'd1;
    end
  end

endmodule

@@ src/ethp_queue.sv @@
module ethp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ethp_pkg::frame_rec_t rec_in,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output ethp_pkg::frame_rec_t rec_out
);

  ethp_pkg::frame_rec_t entries [ethp_pkg::QUEUE_DEPTH];
  logic [ethp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [ethp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [ethp_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  localparam logic [ethp_pkg::QUEUE_PTR_W-1:0] LastIdx =
    ethp_pkg::QUEUE_PTR_W'(ethp_pkg::QUEUE_DEPTH - 1);
  localparam logic [ethp_pkg::QUEUE_CNT_W-1:0] DepthCnt =
    ethp_pkg::QUEUE_CNT_W'(ethp_pkg::QUEUE_DEPTH);
  localparam logic [ethp_pkg::QUEUE_CNT_W-1:0] OneCnt =
    ethp_pkg::QUEUE_CNT_W'(1);

  assign full = (count == DepthCnt);
  assign valid = (count != '0);
  assign rec_out = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + OneCnt;
        2'b01: count <= count - OneCnt;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/ethp_back.sv @@
module ethp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ethp_pkg::frame_rec_t rec,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [47:0]          dest_mac,
  output logic [47:0]          source_mac,
  output logic [31:0]          source_ip,
  output logic [31:0]          dest_ip,
  output logic [7:0]           protocol_number,
  output logic [15:0]          source_port,
  output logic [15:0]          dest_port,
  output logic [7:0]           tcp_flag_bits,
  output logic [15:0]          payload_length,
  output logic [31:0]          packet_number
);

  logic [2:0] st;
  logic [7:0] tcp_need;
  logic [6:0] hdr_bytes;
  logic [15:0] hdr16;
  logic [15:0] pay_len;

  assign pop = q_valid && (!out_valid || out_ready);

  assign tcp_need = ethp_pkg::EthHdr8 + {2'b00, rec.ip_words, 2'b00} + 8'd14;
  assign hdr_bytes = {1'b0, rec.ip_words, 2'b00} + {1'b0, rec.tcp_words, 2'b00};
  assign hdr16 = {9'd0, hdr_bytes};
  assign pay_len = (rec.total_len > hdr16) ? rec.total_len - hdr16 : 16'd0;

  always_comb begin
    if (rec.frame_len <= ethp_pkg::EthHdr8) begin
      st = ethp_pkg::ST_TRUNC;
    end else if (rec.ip_words < ethp_pkg::MinHdrWords) begin
      st = ethp_pkg::ST_BAD_IP;
    end else if (rec.frame_len < ethp_pkg::EthHdr8 + 8'd20) begin
      st = ethp_pkg::ST_TRUNC;
    end else if (rec.proto != ethp_pkg::PROTO_TCP) begin
      if (rec.proto == ethp_pkg::PROTO_UDP) begin
        st = ethp_pkg::ST_UDP;
      end else if (rec.proto == ethp_pkg::PROTO_ICMP) begin
        st = ethp_pkg::ST_ICMP;
      end else if (rec.proto == ethp_pkg::PROTO_IP) begin
        st = ethp_pkg::ST_IP;
      end else begin
        st = ethp_pkg::ST_OTHER;
      end
    end else if (rec.frame_len < tcp_need) begin
      st = ethp_pkg::ST_TRUNC;
    end else if (rec.tcp_words < ethp_pkg::MinHdrWords) begin
      st = ethp_pkg::ST_BAD_TCP;
    end else begin
      st = ethp_pkg::ST_TCP_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= st;
      packet_number <= rec.pkt_num;
      if (st != ethp_pkg::ST_TRUNC) begin
        dest_mac <= rec.dmac;
        source_mac <= rec.smac;
      end else begin
        dest_mac <= '0;
        source_mac <= '0;
      end
      if (st != ethp_pkg::ST_TRUNC && st != ethp_pkg::ST_BAD_IP) begin
        source_ip <= rec.sip;
        dest_ip <= rec.dip;
        protocol_number <= rec.proto;
      end else begin
        source_ip <= '0;
        dest_ip <= '0;
        protocol_number <= '0;
      end
      if (st == ethp_pkg::ST_TCP_OK) begin
        source_port <= rec.sport;
        dest_port <= rec.dport;
        tcp_flag_bits <= rec.flags;
        payload_length <= pay_len;
      end else begin
        source_port <= '0;
        dest_port <= '0;
        tcp_flag_bits <= '0;
        payload_length <= '0;
      end
    end
  end

endmodule

@@ src/eth_ipv4_tcp_header_parser_core.sv @@
// Frame header parser: takes one frame byte per clock while in_ready is high, with last_byte
// marking the end, and returns one result per frame. The byte capture logic hands each
// finished frame to a two-entry queue, and a classifier with an output register drains it,
// so in_ready drops only when both queue entries are held, which happens only after the
// output register has waited on out_ready; with out_ready high and the queue not full the
// block takes a byte and can deliver a result every cycle, even for back-to-back one-byte frames.
module eth_ipv4_tcp_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [47:0] dest_mac,
  output logic [47:0] source_mac,
  output logic [31:0] source_ip,
  output logic [31:0] dest_ip,
  output logic [7:0]  protocol_number,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [7:0]  tcp_flag_bits,
  output logic [15:0] payload_length,
  output logic [31:0] packet_number
);

  ethp_pkg::frame_rec_t front_rec;
  ethp_pkg::frame_rec_t back_rec;
  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;

  ethp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .push      (q_push),
    .rec       (front_rec)
  );

  ethp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .rec_in  (front_rec),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rec_out (back_rec)
  );

  ethp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .rec             (back_rec),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .dest_mac        (dest_mac),
    .source_mac      (source_mac),
    .source_ip       (source_ip),
    .dest_ip         (dest_ip),
    .protocol_number (protocol_number),
    .source_port     (source_port),
    .dest_port       (dest_port),
    .tcp_flag_bits   (tcp_flag_bits),
    .payload_length  (payload_length),
    .packet_number   (packet_number)
  );

  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ethp_pkg::ST_TCP_OK |->
      payload_length == 16'd0 && source_port == 16'd0 && dest_port == 16'd0)
    else $error("TCP fields set on a non-TCP result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ethp_pkg::ST_BAD_IP || status == ethp_pkg::ST_TRUNC) |->
      source_ip == 32'd0 && dest_ip == 32'd0 && protocol_number == 8'd0)
    else $error("IP fields set on a result without a usable IP header");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ethp_pkg::ST_TRUNC |->
      dest_mac == 48'd0 && source_mac == 48'd0)
    else $error("MAC fields set on a truncated result");

endmodule

@@ sim/header_check_pkg.sv @@
package header_check_pkg;

  import ethp_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flags;
    logic [15:0] payload_len;
    logic [31:0] pkt_num;
  } parse_result_t;

  class frame_header_model;
    logic [6:0]    byte_pos;
    logic [3:0]    ip_words;
    logic [3:0]    tcp_words;
    logic [15:0]   total_len;
    logic [47:0]   dmac;
    logic [47:0]   smac;
    logic [31:0]   sip;
    logic [31:0]   dip;
    logic [7:0]    proto;
    logic [15:0]   sport;
    logic [15:0]   dport;
    logic [7:0]    flags;
    logic [31:0]   frame_count;
    parse_result_t expected_headers[$];
    int            mismatch_count;

    function new();
      clear_frame();
      frame_count = 32'd1;
      mismatch_count = 0;
    endfunction

    function void clear_frame();
      byte_pos = '0;
      ip_words = '0;
      tcp_words = '0;
      total_len = '0;
      dmac = '0;
      smac = '0;
      sip = '0;
      dip = '0;
      proto = '0;
      sport = '0;
      dport = '0;
      flags = '0;
    endfunction

    function void take_byte(input logic [7:0] b, input logic is_last);
      int p;
      int o;
      int t;
      int n;
      int hdr;
      parse_result_t r;
      p = int'(byte_pos);
      n = p + 1;
      if (p < 6) dmac[8*(5-p) +: 8] = b;
      else if (p < 12) smac[8*(11-p) +: 8] = b;
      if (p >= ETH_HEADER_BYTES) begin
        o = p - ETH_HEADER_BYTES;
        if (o == 0) ip_words = b[3:0];
        else if (o == 2) total_len[15:8] = b;
        else if (o == 3) total_len[7:0] = b;
        else if (o == 9) proto = b;
        else if (o >= 12 && o <= 15) sip[8*(15-o) +: 8] = b;
        else if (o >= 16 && o <= 19) dip[8*(19-o) +: 8] = b;
        if (ip_words >= MinHdrWords && o >= 4 * int'(ip_words)) begin
          t = o - 4 * int'(ip_words);
          if (t <= 1) sport[8*(1-t) +: 8] = b;
          else if (t <= 3) dport[8*(3-t) +: 8] = b;
          else if (t == 12) tcp_words = b[7:4];
          else if (t == 13) flags = b;
        end
      end
      if (byte_pos < MaxPos) byte_pos = byte_pos + 7'd1;
      if (!is_last) return;

      r = '0;
      hdr = 4 * int'(ip_words) + 4 * int'(tcp_words);
      if (n <= ETH_HEADER_BYTES) r.status = ST_TRUNC;
      else if (ip_words < MinHdrWords) r.status = ST_BAD_IP;
      else if (n < ETH_HEADER_BYTES + 20) r.status = ST_TRUNC;
      else if (proto == PROTO_UDP) r.status = ST_UDP;
      else if (proto == PROTO_ICMP) r.status = ST_ICMP;
      else if (proto == PROTO_IP) r.status = ST_IP;
      else if (proto != PROTO_TCP) r.status = ST_OTHER;
      else if (n < ETH_HEADER_BYTES + 4 * int'(ip_words) + 14) r.status = ST_TRUNC;
      else if (tcp_words < MinHdrWords) r.status = ST_BAD_TCP;
      else r.status = ST_TCP_OK;

      if (r.status != ST_TRUNC) begin
        r.dmac = dmac;
        r.smac = smac;
      end
      if (r.status != ST_TRUNC && r.status != ST_BAD_IP) begin
        r.sip = sip;
        r.dip = dip;
        r.proto = proto;
      end
      if (r.status == ST_TCP_OK) begin
        r.sport = sport;
        r.dport = dport;
        r.flags = flags;
        r.payload_len = (int'(total_len) > hdr) ? 16'(int'(total_len) - hdr) : 16'd0;
      end
      r.pkt_num = frame_count;
      expected_headers.push_back(r);
      frame_count = frame_count + 32'd1;
      clear_frame();
    endfunction

    function void check_result(input parse_result_t got);
      parse_result_t want;
      if (expected_headers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d packet %0d", got.status, got.pkt_num);
        return;
      end
      want = expected_headers.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch on packet %0d", want.pkt_num);
          $display("  expected st %0d mac %h %h ip %h %h pr %0d port %0d %0d fl %h len %0d n %0d",
                   want.status, want.dmac, want.smac, want.sip, want.dip, want.proto,
                   want.sport, want.dport, want.flags, want.payload_len, want.pkt_num);
          $display("  actual   st %0d mac %h %h ip %h %h pr %0d port %0d %0d fl %h len %0d n %0d",
                   got.status, got.dmac, got.smac, got.sip, got.dip, got.proto,
                   got.sport, got.dport, got.flags, got.payload_len, got.pkt_num);
        end
      end
    endfunction
  endclass

endpackage

@@ sim/eth_ipv4_tcp_header_parser_core_test.sv @@
module eth_ipv4_tcp_header_parser_core_test;
  import ethp_pkg::*;
  import header_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [7:0]  protocol_number;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flag_bits;
  logic [15:0] payload_length;
  logic [31:0] packet_number;

  frame_header_model header_model;
  logic [7:0]        frame_q[$];
  int                bytes_sent = 0;
  int                frames_sent = 0;

  eth_ipv4_tcp_header_parser_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .dest_mac(dest_mac),
    .source_mac(source_mac),
    .source_ip(source_ip),
    .dest_ip(dest_ip),
    .protocol_number(protocol_number),
    .source_port(source_port),
    .dest_port(dest_port),
    .tcp_flag_bits(tcp_flag_bits),
    .payload_length(payload_length),
    .packet_number(packet_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit no_gaps);
    int gap;
    data_byte <= b;
    last_byte <= is_last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    header_model.take_byte(b, is_last);
    bytes_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1, no_gaps);
    frames_sent++;
  endtask

  task automatic build_random_frame();
    int         kind;
    int         ihl;
    int         offset;
    int         hdr;
    int         cut;
    logic [7:0] proto;
    logic [15:0] total;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat (12) frame_q.push_back(8'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      frame_q.push_back(8'h08);
      frame_q.push_back(8'h00);
    end else begin
      repeat (2) frame_q.push_back(8'($urandom));
    end

    if (kind < 20) ihl = $urandom_range(0, 4);
    else ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    if (kind < 75) begin
      proto = PROTO_TCP;
    end else begin
      case ($urandom_range(0, 3))
        0: proto = PROTO_UDP;
        1: proto = PROTO_ICMP;
        2: proto = PROTO_IP;
        default: proto = 8'($urandom);
      endcase
    end
    if (kind >= 65 && kind < 75) offset = $urandom_range(0, 4);
    else offset = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;

    hdr = 4 * ihl + 4 * offset;
    case ($urandom_range(0, 2))
      0: total = 16'($urandom);
      1: total = 16'(hdr + $urandom_range(0, 64));
      default: total = 16'($urandom_range(0, hdr));
    endcase

    frame_q.push_back({4'($urandom), 4'(ihl)});
    frame_q.push_back(8'($urandom));
    frame_q.push_back(total[15:8]);
    frame_q.push_back(total[7:0]);
    repeat (5) frame_q.push_back(8'($urandom));
    frame_q.push_back(proto);
    repeat (10) frame_q.push_back(8'($urandom));
    if (ihl > 5) repeat (4 * ihl - 20) frame_q.push_back(8'($urandom));

    if (proto == PROTO_TCP && ihl >= 5) begin
      repeat (12) frame_q.push_back(8'($urandom));
      frame_q.push_back({4'(offset), 4'($urandom)});
      frame_q.push_back(8'($urandom));
      repeat (((offset > 5) ? 4 * offset : 20) - 14) frame_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 99) < 5) repeat ($urandom_range(60, 100)) frame_q.push_back(8'($urandom));
    else repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom));

    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  initial begin : ready_pattern
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    parse_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{status, dest_mac, source_mac, source_ip, dest_ip, protocol_number,
               source_port, dest_port, tcp_flag_bits, payload_length, packet_number};
      header_model.check_result(seen);
    end
  end

  initial begin : stimulus
    header_model = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-byte frames, then a frame whose header length nibble is below the minimum.
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hff};
    send_frame();
    frame_q.delete();
    repeat (12) frame_q.push_back(8'hff);
    frame_q.push_back(8'h08);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h40);
    send_frame();

    while (bytes_sent < 1150) begin
      build_random_frame();
      send_frame();
    end
    in_valid <= 1'b0;

    while (header_model.expected_headers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (header_model.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
